@@ design/r2a_pkg.sv @@
// shared types, codes and the digit-to-character function for the radix converter
package r2a_pkg;

  localparam int unsigned FieldValueW = 64;
  localparam int unsigned FieldRadixW = 2;
  localparam int unsigned FieldCharW  = 8;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [3:0] DigitTen  = 4'd10;

  typedef enum logic [1:0] {
    RADIX_DEC = 2'd0,
    RADIX_HEX = 2'd1,
    RADIX_OCT = 2'd2,
    RADIX_BIN = 2'd3
  } radix_e;

  typedef struct packed {
    logic [FieldValueW-1:0] value;
    logic [FieldRadixW-1:0] radix_select;
  } req_t;

  typedef struct packed {
    logic [FieldCharW-1:0] char_out;
    logic                  last_char;
  } res_t;

  function automatic logic [7:0] digit_ascii(input logic [3:0] digit);
    logic [7:0] ch;
    if (digit < DigitTen) begin
      ch = CharZero + {4'd0, digit};
    end else begin
      ch = CharLowA + {4'd0, digit - DigitTen};
    end
    return ch;
  endfunction

endpackage

@@ design/r2a_extract.sv @@
// digit extraction: bit-serial double dabble for decimal, digit-per-cycle split into the store
module r2a_extract #(
  parameter int unsigned MAX_DIGITS  = 64,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  r2a_pkg::req_t                         req_i,
  output logic                                  busy_o,
  output logic                                  wr_en_o,
  output logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] wr_addr_o,
  output logic [3:0]                            wr_digit_o,
  output logic                                  done_o,
  output logic [$clog2(MAX_DIGITS+1)-1:0]      count_o
);
  import r2a_pkg::*;

  localparam int unsigned NDEC = (VALUE_WIDTH * 30103) / 100000 + 1;
  localparam int unsigned RW   = 4 * NDEC;
  localparam int unsigned CW   = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW   = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int unsigned DW   = $clog2(VALUE_WIDTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_SPLIT
  } state_e;

  state_e                 state_q;
  radix_e                 radix_q;
  logic [RW-1:0]          rem_q;
  logic [RW-1:0]          rem_adj;
  logic [RW-1:0]          rem_shift;
  logic [VALUE_WIDTH-1:0] bin_q;
  logic [DW-1:0]          dab_cnt_q;
  logic [CW-1:0]          n_q;
  logic [3:0]             digit_mask;
  logic                   split_more;

  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      if (rem_q[4*i +: 4] >= 4'd5) begin
        rem_adj[4*i +: 4] = rem_q[4*i +: 4] + 4'd3;
      end else begin
        rem_adj[4*i +: 4] = rem_q[4*i +: 4];
      end
    end
  end

  always_comb begin
    unique case (radix_q)
      RADIX_DEC: begin
        digit_mask = 4'hf;
        rem_shift  = rem_q >> 4;
      end
      RADIX_HEX: begin
        digit_mask = 4'hf;
        rem_shift  = rem_q >> 4;
      end
      RADIX_OCT: begin
        digit_mask = 4'h7;
        rem_shift  = rem_q >> 3;
      end
      RADIX_BIN: begin
        digit_mask = 4'h1;
        rem_shift  = rem_q >> 1;
      end
      default: begin
        digit_mask = 4'hf;
        rem_shift  = rem_q >> 4;
      end
    endcase
  end

  assign split_more = (n_q == '0) || ((rem_q != '0) && (n_q < CW'(MAX_DIGITS)));

  assign busy_o     = (state_q != ST_IDLE);
  assign wr_en_o    = (state_q == ST_SPLIT) && split_more;
  assign wr_addr_o  = n_q[AW-1:0];
  assign wr_digit_o = rem_q[3:0] & digit_mask;
  assign done_o     = (state_q == ST_SPLIT) && !split_more;
  assign count_o    = n_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      radix_q   <= RADIX_DEC;
      rem_q     <= '0;
      bin_q     <= '0;
      dab_cnt_q <= '0;
      n_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (load_i) begin
            radix_q   <= radix_e'(req_i.radix_select);
            n_q       <= '0;
            dab_cnt_q <= '0;
            bin_q     <= req_i.value[VALUE_WIDTH-1:0];
            if (radix_e'(req_i.radix_select) == RADIX_DEC) begin
              rem_q   <= '0;
              state_q <= ST_DABBLE;
            end else begin
              rem_q   <= RW'(req_i.value[VALUE_WIDTH-1:0]);
              state_q <= ST_SPLIT;
            end
          end
        end
        ST_DABBLE: begin
          rem_q     <= {rem_adj[RW-2:0], bin_q[VALUE_WIDTH-1]};
          bin_q     <= {bin_q[VALUE_WIDTH-2:0], 1'b0};
          dab_cnt_q <= dab_cnt_q + DW'(1);
          if (dab_cnt_q == DW'(VALUE_WIDTH - 1)) begin
            state_q <= ST_SPLIT;
          end
        end
        ST_SPLIT: begin
          if (split_more) begin
            rem_q <= rem_shift;
            n_q   <= n_q + CW'(1);
          end else begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ design/r2a_digit_buf.sv @@
// digit store and most-significant-first character readout
module r2a_digit_buf #(
  parameter int unsigned MAX_DIGITS = 64
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  wr_en_i,
  input  logic [((MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1)-1:0] wr_addr_i,
  input  logic [3:0]                            wr_digit_i,
  input  logic                                  go_i,
  input  logic [$clog2(MAX_DIGITS+1)-1:0]      count_i,
  output logic                                  busy_o,
  output logic                                  strobe_o,
  output r2a_pkg::res_t                         result_o
);
  import r2a_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_e;

  state_e        state_q;
  logic [AW-1:0] ptr_q;
  logic          rd_vld_q;
  logic          rd_last_q;
  logic [3:0]    rd_data_q;
  logic [CW-1:0] last_idx;
  logic [3:0]    mem [MAX_DIGITS];

  assign last_idx = count_i - CW'(1);

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_digit_i;
    end
    if (state_q == ST_READ) begin
      rd_data_q <= mem[ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ptr_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_last_q <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          rd_vld_q  <= 1'b0;
          rd_last_q <= 1'b0;
          if (go_i) begin
            ptr_q   <= last_idx[AW-1:0];
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          rd_vld_q  <= 1'b1;
          rd_last_q <= (ptr_q == '0);
          if (ptr_q == '0) begin
            state_q <= ST_IDLE;
          end else begin
            ptr_q <= ptr_q - AW'(1);
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign busy_o             = (state_q != ST_IDLE) || rd_vld_q;
  assign strobe_o           = rd_vld_q;
  assign result_o.char_out  = digit_ascii(rd_data_q);
  assign result_o.last_char = rd_last_q;

endmodule

@@ design/radix_integer_to_ascii_top.sv @@
// top level of the integer to ascii converter for radix 10, 16, 8 and 2
//
//  channel   handshake         payload
//  request   start / busy      req_i   (value, radix_select)
//  result    strobe_o          result_o (char_out, last_char)
//
//  a request in decimal runs the double dabble before the digit split; in
//  hex, octal or binary it goes straight to the split (at most MAX_DIGITS digits)
//  the double dabble is bit-serial and takes one input bit a cycle;
//  the digit split writes one digit a cycle and the store reads one a cycle
//  characters leave on consecutive cycles; busy stays high until the last one
//  reset clears all control state; the digit store needs no clearing
module radix_integer_to_ascii_top #(
  parameter int unsigned MAX_DIGITS  = 64,
  parameter int unsigned VALUE_WIDTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  r2a_pkg::req_t  req_i,
  output logic           strobe_o,
  output r2a_pkg::res_t  result_o
);
  import r2a_pkg::*;

  localparam int unsigned CW = $clog2(MAX_DIGITS + 1);
  localparam int unsigned AW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;

  logic          load;
  logic          ext_busy;
  logic          buf_busy;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [3:0]    wr_digit;
  logic          ext_done;
  logic [CW-1:0] ext_count;

  assign load = start && !busy;
  assign busy = ext_busy || buf_busy;

  r2a_extract #(
    .MAX_DIGITS (MAX_DIGITS),
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_extract (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (load),
    .req_i     (req_i),
    .busy_o    (ext_busy),
    .wr_en_o   (wr_en),
    .wr_addr_o (wr_addr),
    .wr_digit_o(wr_digit),
    .done_o    (ext_done),
    .count_o   (ext_count)
  );

  r2a_digit_buf #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_digit_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_digit_i(wr_digit),
    .go_i      (ext_done),
    .count_i   (ext_count),
    .busy_o    (buf_busy),
    .strobe_o  (strobe_o),
    .result_o  (result_o)
  );

endmodule

@@ design/r2a_checker.sv @@
// port-level checks for the integer to ascii converter, bound to the top level
module r2a_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          start,
  input logic          busy,
  input r2a_pkg::req_t req_i,
  input logic          strobe_o,
  input r2a_pkg::res_t result_o
);
  import r2a_pkg::*;

  logic char_ok;

  assign char_ok = ((result_o.char_out >= CharZero) && (result_o.char_out <= 8'h39)) ||
                   ((result_o.char_out >= CharLowA) && (result_o.char_out <= 8'h66));

  a_busy_after_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after request");

  a_strobe_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> busy)
    else $error("character shown while not busy");

  a_chars_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !result_o.last_char |=> strobe_o)
    else $error("gap inside a character run");

  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy) |-> $past(strobe_o && result_o.last_char))
    else $error("busy dropped without a last character");

  a_char_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o |-> char_ok)
    else $error("character outside digit set");

endmodule

bind radix_integer_to_ascii_top r2a_checker u_r2a_checker (.*);
